/* rtl/core/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg
// Shared constants, codes and types of the string hash set core.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int DEF_SLOTS       = 256;
  localparam int DEF_MAX_KEY     = 63;
  localparam int DEF_SLOT_STRIDE = 64;

  localparam int              HASH_W     = 64;
  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam int              HASH_SHIFT = 5;

  localparam int         CFG_W          = 9;
  localparam logic [8:0] TABLE_SIZE_RST = 9'd256;

  localparam logic [2:0] REQ_INSERT      = 3'd0;
  localparam logic [2:0] REQ_LOOKUP      = 3'd1;
  localparam logic [2:0] REQ_READ_SLOT   = 3'd2;
  localparam logic [2:0] REQ_REMOVE_SLOT = 3'd3;
  localparam logic [2:0] REQ_REMOVE_KEY  = 3'd4;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_ABSENT      = 3'd1;
  localparam logic [2:0] STS_FULL        = 3'd2;
  localparam logic [2:0] STS_DUP         = 3'd3;
  localparam logic [2:0] STS_BAD_INDEX   = 3'd4;
  localparam logic [2:0] STS_SLOT_EMPTY  = 3'd5;
  localparam logic [2:0] STS_TABLE_EMPTY = 3'd6;
  localparam logic [2:0] STS_TOO_LONG    = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLEN,
    S_RDB_ADDR,
    S_RDB_DATA,
    S_DIV,
    S_PRB_RD,
    S_PRB_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_CPY_RD,
    S_CPY_WR,
    S_EMIT
  } fsm_t;

endpackage

/* rtl/core/shs_req_if.sv */
// ----------------------------------------------------------------------------
// shs_req_if
// Request channel: one key byte or one slot request per item.
// ----------------------------------------------------------------------------
interface shs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] key_byte;
  logic       key_last;
  logic [7:0] slot_index;

  modport source (output valid, output req_type, output key_byte, output key_last,
                  output slot_index, input ready);
  modport sink (input valid, input req_type, input key_byte, input key_last,
                input slot_index, output ready);
endinterface

/* rtl/core/shs_rsp_if.sv */
// ----------------------------------------------------------------------------
// shs_rsp_if
// Result channel: one status or one stored key byte per item.
// ----------------------------------------------------------------------------
interface shs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       found;
  logic [7:0] out_byte;
  logic       out_last;
  logic [8:0] element_count;
  logic [7:0] hit_slot;

  modport source (output valid, output status, output found, output out_byte,
                  output out_last, output element_count, output hit_slot, input ready);
  modport sink (input valid, input status, input found, input out_byte,
                input out_last, input element_count, input hit_slot, output ready);
endinterface

/* rtl/core/shs_cfg_if.sv */
// ----------------------------------------------------------------------------
// shs_cfg_if
// Configuration write channel for the table size register.
// ----------------------------------------------------------------------------
interface shs_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink (input valid, input table_size, output ready);
endinterface

/* rtl/core/shs_ram.sv */
// ----------------------------------------------------------------------------
// shs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module shs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/shs_mod.sv */
// ----------------------------------------------------------------------------
// shs_mod
// Bit-serial remainder of the 64-bit hash by the table size.
// ----------------------------------------------------------------------------
module shs_mod #(
  parameter int DIV_W = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [shs_pkg::HASH_W-1:0]  dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [DIV_W-1:0]            rem
);

  localparam int CNT_W = $clog2(shs_pkg::HASH_W);

  logic [shs_pkg::HASH_W-1:0] dvd;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [DIV_W:0]             trial;
  logic [DIV_W:0]             trial_sub;

  // One dividend bit per cycle: shift it in, subtract when the partial fits.
  assign trial     = {rem, dvd[shs_pkg::HASH_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= (trial >= {1'b0, divisor}) ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd <= dvd << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(shs_pkg::HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(start && busy))
    else $error("shs_mod: start while a remainder is in progress");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("shs_mod: done held for more than one cycle");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("shs_mod: remainder not below the divisor");

endmodule

/* rtl/core/string_hash_set_linear_probe_core.sv */
// ----------------------------------------------------------------------------
// string_hash_set_linear_probe_core
// Open-addressing string set with DJB2 hashing and linear probing.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | req_type, key_byte, key_last, slot_index
//  rsp     | out | valid / ready | status, found, out_byte, out_last,
//          |     |               | element_count, hit_slot
//  cfg     | in  | valid / ready | table_size
//
// A key byte that is not the last is hashed and buffered as it is taken. A last key
// byte starts the serial remainder unit; then each probed slot has its length read and
// checked, each compared byte is read and checked, each byte copied on insert is read
// and written, and the result is posted. A key too long, a full table or an empty
// table goes straight to the result. Read slot reads the slot length, then each byte;
// a bad index, or an empty table on remove slot, goes straight to the result, an empty
// slot and remove slot after the length read. After reset the slot length memory is
// cleared, one slot a cycle, before the first item is taken. A result waits in the
// output register; the core stalls on the next result until that register frees.
module string_hash_set_linear_probe_core #(
  parameter int SLOTS       = shs_pkg::DEF_SLOTS,
  parameter int MAX_KEY     = shs_pkg::DEF_MAX_KEY,
  parameter int SLOT_STRIDE = shs_pkg::DEF_SLOT_STRIDE
) (
  input logic      clk,
  input logic      rst,
  shs_req_if.sink  req,
  shs_rsp_if.source rsp,
  shs_cfg_if.sink  cfg
);

  localparam int KEY_LIMIT = (MAX_KEY < SLOT_STRIDE) ? MAX_KEY : SLOT_STRIDE;
  localparam int SI_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SZ_W      = $clog2(SLOTS + 1);
  localparam int LEN_W     = $clog2(KEY_LIMIT + 2);
  localparam int KI_W      = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;
  localparam int BYTES     = SLOTS * SLOT_STRIDE;
  localparam int BA_W      = $clog2(BYTES);
  localparam int HW        = shs_pkg::HASH_W;

  shs_pkg::fsm_t state, state_next;

  logic [shs_pkg::CFG_W-1:0] cfg_size;
  logic [SZ_W-1:0]  size_eff;
  logic [HW-1:0]    hash, hash_next, new_hash;
  logic [LEN_W-1:0] in_len, in_len_next, in_len_inc;
  logic [2:0]       op_type, op_type_next;
  logic [LEN_W-1:0] op_len, op_len_next;
  logic [LEN_W-1:0] rd_len, rd_len_next;
  logic [LEN_W-1:0] cnt_i, cnt_i_next, cnt_inc;
  logic [SI_W-1:0]  pos, pos_next, start_pos, start_pos_next, pos_inc;
  logic [SZ_W-1:0]  count, count_next;
  logic [2:0]       res_status, res_status_next;
  logic             res_found, res_found_next;
  logic [SI_W-1:0]  res_slot, res_slot_next;

  logic             o_valid, o_valid_next;
  logic [2:0]       o_status, o_status_next;
  logic             o_found, o_found_next;
  logic [7:0]       o_byte, o_byte_next;
  logic             o_last, o_last_next;
  logic [8:0]       o_count, o_count_next;
  logic [7:0]       o_slot, o_slot_next;

  logic             acc, out_free, wrapped;
  logic             div_start, div_done;
  logic [SZ_W-1:0]  div_rem;

  logic             len_we, len_re;
  logic [SI_W-1:0]  len_waddr, len_raddr;
  logic [LEN_W-1:0] len_wdata, len_rd;
  logic             key_we, key_re;
  logic [KI_W-1:0]  key_waddr, key_raddr;
  logic [7:0]       key_rd;
  logic             byte_we, byte_re;
  logic [BA_W-1:0]  byte_addr;
  logic [7:0]       byte_rd;

  assign req.ready = (state == shs_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign acc       = req.valid && req.ready;
  assign out_free  = !o_valid || rsp.ready;

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.found         = o_found;
  assign rsp.out_byte      = o_byte;
  assign rsp.out_last      = o_last;
  assign rsp.element_count = o_count;
  assign rsp.hit_slot      = o_slot;

  // A size of zero acts as one slot, a size above SLOTS as SLOTS.
  always_comb begin
    logic [31:0] sz;
    sz = 32'(cfg_size);
    if (sz == 32'd0) begin
      sz = 32'd1;
    end
    if (sz > 32'(SLOTS)) begin
      sz = 32'(SLOTS);
    end
    size_eff = SZ_W'(sz);
  end

  assign new_hash   = (hash << shs_pkg::HASH_SHIFT) + hash
                    + {{(HW-8){req.key_byte[7]}}, req.key_byte};
  assign in_len_inc = (32'(in_len) <= KEY_LIMIT) ? in_len + 1'b1 : in_len;
  assign cnt_inc    = cnt_i + 1'b1;
  assign pos_inc    = (32'(pos) + 32'd1 >= 32'(size_eff)) ? '0 : pos + 1'b1;
  assign wrapped    = (pos_inc == start_pos);
  assign byte_addr  = BA_W'(32'(pos) * 32'(SLOT_STRIDE) + 32'(cnt_i));

  always_comb begin
    state_next      = state;
    hash_next       = hash;
    in_len_next     = in_len;
    op_type_next    = op_type;
    op_len_next     = op_len;
    rd_len_next     = rd_len;
    cnt_i_next      = cnt_i;
    pos_next        = pos;
    start_pos_next  = start_pos;
    count_next      = count;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_slot_next   = res_slot;
    o_valid_next    = o_valid && !rsp.ready;
    o_status_next   = o_status;
    o_found_next    = o_found;
    o_byte_next     = o_byte;
    o_last_next     = o_last;
    o_count_next    = o_count;
    o_slot_next     = o_slot;
    div_start       = 1'b0;
    len_we          = 1'b0;
    len_waddr       = pos;
    len_wdata       = '0;
    len_re          = 1'b0;
    len_raddr       = pos;
    key_we          = 1'b0;
    key_waddr       = in_len[KI_W-1:0];
    key_re          = 1'b0;
    key_raddr       = cnt_i[KI_W-1:0];
    byte_we         = 1'b0;
    byte_re         = 1'b0;

    case (state)
      shs_pkg::S_CLEAR: begin
        len_we   = 1'b1;
        pos_next = pos + 1'b1;
        if (32'(pos) == SLOTS - 1) begin
          pos_next   = '0;
          state_next = shs_pkg::S_IDLE;
        end
      end
      shs_pkg::S_IDLE: begin
        if (acc) begin
          if (req.req_type > shs_pkg::REQ_REMOVE_KEY) begin
            hash_next   = shs_pkg::HASH_SEED;
            in_len_next = '0;
          end else if (req.req_type == shs_pkg::REQ_READ_SLOT ||
                       req.req_type == shs_pkg::REQ_REMOVE_SLOT) begin
            hash_next       = shs_pkg::HASH_SEED;
            in_len_next     = '0;
            op_type_next    = req.req_type;
            res_found_next  = 1'b0;
            res_slot_next   = '0;
            if (req.req_type == shs_pkg::REQ_REMOVE_SLOT && count == '0) begin
              res_status_next = shs_pkg::STS_TABLE_EMPTY;
              state_next      = shs_pkg::S_EMIT;
            end else if (32'(req.slot_index) >= 32'(size_eff)) begin
              res_status_next = shs_pkg::STS_BAD_INDEX;
              state_next      = shs_pkg::S_EMIT;
            end else begin
              pos_next   = SI_W'(req.slot_index);
              len_re     = 1'b1;
              len_raddr  = SI_W'(req.slot_index);
              state_next = shs_pkg::S_SLEN;
            end
          end else begin
            hash_next   = new_hash;
            key_we      = (32'(in_len) < KEY_LIMIT);
            in_len_next = in_len_inc;
            if (req.key_last) begin
              hash_next       = shs_pkg::HASH_SEED;
              in_len_next     = '0;
              op_type_next    = req.req_type;
              op_len_next     = in_len_inc;
              res_found_next  = 1'b0;
              res_slot_next   = '0;
              if (32'(in_len_inc) > KEY_LIMIT) begin
                res_status_next = shs_pkg::STS_TOO_LONG;
                state_next      = shs_pkg::S_EMIT;
              end else if (req.req_type == shs_pkg::REQ_INSERT &&
                           32'(count) >= 32'(size_eff)) begin
                res_status_next = shs_pkg::STS_FULL;
                state_next      = shs_pkg::S_EMIT;
              end else if (req.req_type == shs_pkg::REQ_REMOVE_KEY && count == '0) begin
                res_status_next = shs_pkg::STS_TABLE_EMPTY;
                state_next      = shs_pkg::S_EMIT;
              end else begin
                div_start  = 1'b1;
                state_next = shs_pkg::S_DIV;
              end
            end
          end
        end
      end
      shs_pkg::S_SLEN: begin
        if (len_rd == '0) begin
          res_status_next = shs_pkg::STS_SLOT_EMPTY;
          state_next      = shs_pkg::S_EMIT;
        end else if (op_type == shs_pkg::REQ_REMOVE_SLOT) begin
          len_we          = 1'b1;
          count_next      = count - 1'b1;
          res_status_next = shs_pkg::STS_OK;
          res_slot_next   = pos;
          state_next      = shs_pkg::S_EMIT;
        end else begin
          rd_len_next = len_rd;
          cnt_i_next  = '0;
          state_next  = shs_pkg::S_RDB_ADDR;
        end
      end
      shs_pkg::S_RDB_ADDR: begin
        byte_re    = 1'b1;
        state_next = shs_pkg::S_RDB_DATA;
      end
      shs_pkg::S_RDB_DATA: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_status_next = shs_pkg::STS_OK;
          o_found_next  = 1'b0;
          o_byte_next   = byte_rd;
          o_last_next   = (cnt_inc == rd_len);
          o_count_next  = 9'(count);
          o_slot_next   = 8'(pos);
          cnt_i_next    = cnt_inc;
          state_next    = (cnt_inc == rd_len) ? shs_pkg::S_IDLE : shs_pkg::S_RDB_ADDR;
        end
      end
      shs_pkg::S_DIV: begin
        if (div_done) begin
          pos_next       = SI_W'(div_rem);
          start_pos_next = SI_W'(div_rem);
          state_next     = shs_pkg::S_PRB_RD;
        end
      end
      shs_pkg::S_PRB_RD: begin
        len_re     = 1'b1;
        state_next = shs_pkg::S_PRB_CHK;
      end
      shs_pkg::S_PRB_CHK, shs_pkg::S_CMP_CHK: begin
        // Both checks fall back to the next slot on a miss, unless the probe has wrapped to its start.
        if (state == shs_pkg::S_PRB_CHK && len_rd == '0) begin
          if (op_type == shs_pkg::REQ_INSERT) begin
            cnt_i_next = '0;
            state_next = shs_pkg::S_CPY_RD;
          end else begin
            res_status_next = shs_pkg::STS_ABSENT;
            state_next      = shs_pkg::S_EMIT;
          end
        end else if (state == shs_pkg::S_PRB_CHK && len_rd == op_len) begin
          cnt_i_next = '0;
          state_next = shs_pkg::S_CMP_RD;
        end else if (state == shs_pkg::S_CMP_CHK && key_rd == byte_rd &&
                     cnt_inc != op_len) begin
          cnt_i_next = cnt_inc;
          state_next = shs_pkg::S_CMP_RD;
        end else if (state == shs_pkg::S_CMP_CHK && key_rd == byte_rd) begin
          res_slot_next = pos;
          state_next    = shs_pkg::S_EMIT;
          case (op_type)
            shs_pkg::REQ_INSERT: res_status_next = shs_pkg::STS_DUP;
            shs_pkg::REQ_LOOKUP: begin
              res_status_next = shs_pkg::STS_OK;
              res_found_next  = 1'b1;
            end
            default: begin
              len_we          = 1'b1;
              count_next      = count - 1'b1;
              res_status_next = shs_pkg::STS_OK;
            end
          endcase
        end else if (wrapped) begin
          res_status_next = (op_type == shs_pkg::REQ_INSERT) ? shs_pkg::STS_FULL
                                                             : shs_pkg::STS_ABSENT;
          state_next      = shs_pkg::S_EMIT;
        end else begin
          pos_next   = pos_inc;
          state_next = shs_pkg::S_PRB_RD;
        end
      end
      shs_pkg::S_CMP_RD: begin
        key_re     = 1'b1;
        byte_re    = 1'b1;
        state_next = shs_pkg::S_CMP_CHK;
      end
      shs_pkg::S_CPY_RD: begin
        key_re     = 1'b1;
        state_next = shs_pkg::S_CPY_WR;
      end
      shs_pkg::S_CPY_WR: begin
        byte_we = 1'b1;
        if (cnt_inc == op_len) begin
          len_we          = 1'b1;
          len_wdata       = op_len;
          count_next      = count + 1'b1;
          res_status_next = shs_pkg::STS_OK;
          res_slot_next   = pos;
          state_next      = shs_pkg::S_EMIT;
        end else begin
          cnt_i_next = cnt_inc;
          state_next = shs_pkg::S_CPY_RD;
        end
      end
      shs_pkg::S_EMIT: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_status_next = res_status;
          o_found_next  = res_found;
          o_byte_next   = '0;
          o_last_next   = 1'b1;
          o_count_next  = 9'(count);
          o_slot_next   = 8'(res_slot);
          state_next    = shs_pkg::S_IDLE;
        end
      end
      default: state_next = shs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= shs_pkg::S_CLEAR;
      cfg_size <= shs_pkg::TABLE_SIZE_RST;
      hash     <= shs_pkg::HASH_SEED;
      in_len   <= '0;
      count    <= '0;
      pos      <= '0;
      o_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      hash    <= hash_next;
      in_len  <= in_len_next;
      count   <= count_next;
      pos     <= pos_next;
      o_valid <= o_valid_next;
      if (cfg.valid) begin
        cfg_size <= cfg.table_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_type    <= op_type_next;
    op_len     <= op_len_next;
    rd_len     <= rd_len_next;
    cnt_i      <= cnt_i_next;
    start_pos  <= start_pos_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_slot   <= res_slot_next;
    o_status   <= o_status_next;
    o_found    <= o_found_next;
    o_byte     <= o_byte_next;
    o_last     <= o_last_next;
    o_count    <= o_count_next;
    o_slot     <= o_slot_next;
  end

  shs_mod #(.DIV_W(SZ_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_hash),
    .divisor  (size_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  shs_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rd)
  );

  shs_ram #(.WIDTH(8), .DEPTH(BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_addr),
    .wdata (key_rd),
    .re    (byte_re),
    .raddr (byte_addr),
    .rdata (byte_rd)
  );

  shs_ram #(.WIDTH(8), .DEPTH(KEY_LIMIT)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (req.key_byte),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= SLOTS)
    else $error("element count above the slot count");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == shs_pkg::S_DIV)
    else $error("remainder finished outside the hash state");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == shs_pkg::S_PRB_RD |-> 32'(pos) < 32'(size_eff))
    else $error("probe slot beyond the table size");

  a_byte_in_key: assert property (@(posedge clk) disable iff (rst)
    (state == shs_pkg::S_CMP_RD || state == shs_pkg::S_CPY_RD) |-> cnt_i < op_len)
    else $error("byte index beyond the key length");

endmodule

/* dv/shs_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_scoreboard
// Watches the request, result and configuration channels of the string hash
// set core, keeps its own copy of the table and compares every result item.
// ----------------------------------------------------------------------------
module shs_scoreboard (
  input  logic clk,
  input  logic rst,
  shs_req_if   req,
  shs_rsp_if   rsp,
  shs_cfg_if   cfg,
  output int   errors,
  output int   n_waiting
);

  localparam int KEY_LIMIT = (shs_pkg::DEF_MAX_KEY < shs_pkg::DEF_SLOT_STRIDE) ?
                             shs_pkg::DEF_MAX_KEY : shs_pkg::DEF_SLOT_STRIDE;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [7:0] out_byte;
    logic       out_last;
    logic [8:0] element_count;
    logic [7:0] hit_slot;
  } result_t;

  result_t     result_q[$];
  logic [6:0]  slot_len[shs_pkg::DEF_SLOTS];
  logic [7:0]  slot_data[shs_pkg::DEF_SLOTS][shs_pkg::DEF_SLOT_STRIDE];
  logic [7:0]  key_buf[KEY_LIMIT];
  int unsigned key_len;
  logic [63:0] hash_acc;
  logic [8:0]  occupied;
  logic [8:0]  table_size;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic push(input logic [2:0] st, input logic fnd, input logic [7:0] ob,
                      input logic lst, input logic [7:0] slot);
    result_t r;
    r.status = st; r.found = fnd; r.out_byte = ob; r.out_last = lst;
    r.element_count = occupied; r.hit_slot = slot;
    result_q.push_back(r);
  endtask

  // Returns 0 on a free slot, 1 on a match, 2 when the probe wrapped around.
  function automatic int probe_table(input logic [63:0] h, input int unsigned len,
                                     input int unsigned size, output int unsigned pos);
    int unsigned start;
    int unsigned p;
    bit same;
    start = 32'(h % 64'(size));
    p = start;
    do begin
      if (slot_len[p] == 0) begin
        pos = p;
        return 0;
      end
      if (slot_len[p] == len) begin
        same = 1;
        for (int i = 0; i < len; i++) if (slot_data[p][i] != key_buf[i]) same = 0;
        if (same) begin
          pos = p;
          return 1;
        end
      end
      p = (p + 1) % size;
    end while (p != start);
    pos = 0;
    return 2;
  endfunction

  task automatic predict(input logic [2:0] rt, input logic [7:0] b, input logic lst,
                         input logic [7:0] idx);
    int unsigned size;
    int unsigned len;
    int unsigned pos;
    int r;
    logic [63:0] h;
    size = (table_size == 0) ? 1 :
           ((table_size > shs_pkg::DEF_SLOTS) ? shs_pkg::DEF_SLOTS : table_size);
    if (rt > shs_pkg::REQ_REMOVE_KEY) begin
      key_len = 0; hash_acc = shs_pkg::HASH_SEED;
      return;
    end
    if (rt == shs_pkg::REQ_READ_SLOT || rt == shs_pkg::REQ_REMOVE_SLOT) begin
      key_len = 0; hash_acc = shs_pkg::HASH_SEED;
      if (rt == shs_pkg::REQ_REMOVE_SLOT && occupied == 0)
        push(shs_pkg::STS_TABLE_EMPTY, 0, 0, 1, 0);
      else if (idx >= size) push(shs_pkg::STS_BAD_INDEX, 0, 0, 1, 0);
      else if (slot_len[idx] == 0) push(shs_pkg::STS_SLOT_EMPTY, 0, 0, 1, 0);
      else if (rt == shs_pkg::REQ_REMOVE_SLOT) begin
        slot_len[idx] = 0;
        occupied--;
        push(shs_pkg::STS_OK, 0, 0, 1, idx);
      end else begin
        for (int i = 0; i < slot_len[idx]; i++)
          push(shs_pkg::STS_OK, 0, slot_data[idx][i], (i + 1 == slot_len[idx]), idx);
      end
      return;
    end
    // Key bytes are hashed as signed chars.
    hash_acc = (hash_acc << shs_pkg::HASH_SHIFT) + hash_acc + {{56{b[7]}}, b};
    if (key_len < KEY_LIMIT) key_buf[key_len] = b;
    if (key_len <= KEY_LIMIT) key_len++;
    if (!lst) return;
    len = key_len;
    h = hash_acc;
    key_len = 0; hash_acc = shs_pkg::HASH_SEED;
    if (len > KEY_LIMIT) begin
      push(shs_pkg::STS_TOO_LONG, 0, 0, 1, 0);
      return;
    end
    if (rt == shs_pkg::REQ_INSERT) begin
      if (occupied >= size) begin
        push(shs_pkg::STS_FULL, 0, 0, 1, 0);
        return;
      end
      r = probe_table(h, len, size, pos);
      if (r == 1) push(shs_pkg::STS_DUP, 0, 0, 1, 8'(pos));
      else if (r == 2) push(shs_pkg::STS_FULL, 0, 0, 1, 0);
      else begin
        for (int i = 0; i < len; i++) slot_data[pos][i] = key_buf[i];
        slot_len[pos] = 7'(len);
        occupied++;
        push(shs_pkg::STS_OK, 0, 0, 1, 8'(pos));
      end
    end else if (rt == shs_pkg::REQ_LOOKUP) begin
      r = probe_table(h, len, size, pos);
      if (r == 1) push(shs_pkg::STS_OK, 1, 0, 1, 8'(pos));
      else push(shs_pkg::STS_ABSENT, 0, 0, 1, 0);
    end else begin
      if (occupied == 0) begin
        push(shs_pkg::STS_TABLE_EMPTY, 0, 0, 1, 0);
        return;
      end
      r = probe_table(h, len, size, pos);
      if (r != 1) push(shs_pkg::STS_ABSENT, 0, 0, 1, 0);
      else begin
        slot_len[pos] = 0;
        occupied--;
        push(shs_pkg::STS_OK, 0, 0, 1, 8'(pos));
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < shs_pkg::DEF_SLOTS; i++) slot_len[i] = 0;
      key_len = 0;
      hash_acc = shs_pkg::HASH_SEED;
      occupied = 0;
      table_size = shs_pkg::TABLE_SIZE_RST;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) table_size = cfg.table_size;
      if (req.valid && req.ready)
        predict(req.req_type, req.key_byte, req.key_last, req.slot_index);
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          report("unexpected result item, status", rsp.status, 0);
        end else begin
          want = result_q.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.found !== want.found) report("found", rsp.found, want.found);
          if (rsp.out_byte !== want.out_byte) report("out_byte", rsp.out_byte, want.out_byte);
          if (rsp.out_last !== want.out_last) report("out_last", rsp.out_last, want.out_last);
          if (rsp.element_count !== want.element_count)
            report("element_count", rsp.element_count, want.element_count);
          if (rsp.hit_slot !== want.hit_slot) report("hit_slot", rsp.hit_slot, want.hit_slot);
        end
      end
    end
    n_waiting = result_q.size();
  end

endmodule

/* dv/tb_string_hash_set_linear_probe_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_hash_set_linear_probe_core
// Drives key streams, slot requests and table size writes into the core with
// bursty input and a stalling receiver; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_string_hash_set_linear_probe_core;

  localparam int IDLE_LIMIT = 200000;
  localparam int POOL_N     = 22;

  logic clk;
  logic rst;
  int   errors;
  int   n_waiting;
  int   idle_cycles;
  int   burst_left;
  bit   hold_off;
  logic [7:0] pool[POOL_N][$];
  logic [8:0] cur_size;

  shs_req_if req ();
  shs_rsp_if rsp ();
  shs_cfg_if cfg ();

  string_hash_set_linear_probe_core i_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  shs_scoreboard i_scoreboard (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .errors(errors), .n_waiting(n_waiting)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // The receiver changes its stall pattern every so often.
  always @(posedge clk) begin
    int mode;
    int mode_left;
    if (mode_left == 0) begin
      mode = $urandom_range(2, 0);
      mode_left = $urandom_range(150, 20);
    end else mode_left--;
    if (rst || hold_off) rsp.ready <= 1'b0;
    else case (mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(1, 0) == 1);
      default: rsp.ready <= ($urandom_range(9, 0) == 0);
    endcase
  end

  // One long hold-off while the sender keeps offering key items.
  initial begin
    hold_off = 0;
    @(negedge rst);
    repeat (400) @(posedge clk);
    hold_off = 1;
    repeat (1500) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] rt, input logic [7:0] b, input logic lst,
                           input logic [7:0] idx);
    int gap;
    req.valid <= 1'b1;
    req.req_type <= rt;
    req.key_byte <= b;
    req.key_last <= lst;
    req.slot_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12, 0);
      gap = $urandom_range(6, 1);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Earlier bytes carry a random key request type; only the last one counts.
  task automatic send_key(input logic [2:0] rt, input int k);
    logic [2:0] early;
    for (int i = 0; i < pool[k].size(); i++) begin
      case ($urandom_range(2, 0))
        0: early = shs_pkg::REQ_INSERT;
        1: early = shs_pkg::REQ_LOOKUP;
        default: early = shs_pkg::REQ_REMOVE_KEY;
      endcase
      send_item((i == pool[k].size() - 1) ? rt : early, pool[k][i],
                i == pool[k].size() - 1, 8'($urandom));
    end
  endtask

  task automatic send_slot(input logic [2:0] rt, input logic [7:0] idx);
    send_item(rt, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic write_size(input logic [8:0] value);
    req.valid <= 1'b0;
    while (n_waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.table_size <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_size = value;
  endtask

  task automatic random_op();
    int pick;
    int k;
    logic [7:0] idx;
    pick = $urandom_range(99, 0);
    k = $urandom_range(19, 0);
    if ($urandom_range(3, 0) == 0 || cur_size == 0) idx = 8'($urandom);
    else idx = 8'($urandom_range((cur_size > 256) ? 255 : cur_size - 1, 0));
    if (pick < 35) send_key(shs_pkg::REQ_INSERT, k);
    else if (pick < 55) send_key(shs_pkg::REQ_LOOKUP, k);
    else if (pick < 70) send_key(shs_pkg::REQ_REMOVE_KEY, k);
    else if (pick < 82) send_slot(shs_pkg::REQ_READ_SLOT, idx);
    else if (pick < 92) send_slot(shs_pkg::REQ_REMOVE_SLOT, idx);
    else begin
      // A broken stream: a few key bytes, then an undefined request or a slot request.
      repeat ($urandom_range(3, 1))
        send_item(shs_pkg::REQ_INSERT, 8'($urandom), 1'b0, 8'($urandom));
      if ($urandom_range(1, 0) == 1) send_item(3'($urandom_range(7, 5)), 8'($urandom),
                                               1'($urandom), 8'($urandom));
      else send_slot(shs_pkg::REQ_READ_SLOT, idx);
    end
  endtask

  initial begin
    logic [8:0] sizes[7];
    int len;
    sizes = '{9'd8, 9'd1, 9'd0, 9'd3, 9'd300, 9'd255, 9'd511};
    for (int k = 0; k < POOL_N; k++) begin
      len = (k < 20) ? $urandom_range(3, 1) : ((k == 20) ? 63 : 64);
      for (int i = 0; i < len; i++) pool[k].push_back(8'($urandom));
    end
    pool[0] = '{8'h00};
    pool[1] = '{8'h80, 8'hff, 8'h7f};
    rst = 1'b1;
    req.valid = 1'b0; req.req_type = shs_pkg::REQ_INSERT; req.key_byte = 0;
    req.key_last = 0; req.slot_index = 0;
    cfg.valid = 1'b0; cfg.table_size = shs_pkg::TABLE_SIZE_RST;
    burst_left = 0;
    cur_size = shs_pkg::TABLE_SIZE_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    send_slot(shs_pkg::REQ_REMOVE_SLOT, 8'd0);
    send_key(shs_pkg::REQ_REMOVE_KEY, 2);
    send_slot(shs_pkg::REQ_READ_SLOT, 8'd255);
    send_key(shs_pkg::REQ_INSERT, 0);
    send_key(shs_pkg::REQ_INSERT, 1);
    send_key(shs_pkg::REQ_INSERT, 1);
    send_key(shs_pkg::REQ_LOOKUP, 1);
    send_key(shs_pkg::REQ_LOOKUP, 3);
    send_key(shs_pkg::REQ_INSERT, 20);
    send_key(shs_pkg::REQ_INSERT, 21);
    send_key(shs_pkg::REQ_REMOVE_KEY, 0);
    send_key(shs_pkg::REQ_REMOVE_KEY, 0);
    send_item(3'd7, 8'hff, 1'b1, 8'hff);
    write_size(9'd1);
    send_key(shs_pkg::REQ_INSERT, 4);
    send_key(shs_pkg::REQ_INSERT, 5);
    send_slot(shs_pkg::REQ_READ_SLOT, 8'd0);
    send_slot(shs_pkg::REQ_READ_SLOT, 8'd5);
    send_slot(shs_pkg::REQ_REMOVE_SLOT, 8'd200);
    send_slot(shs_pkg::REQ_REMOVE_SLOT, 8'd0);

    // Random part, in phases of different table sizes.
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      for (int n = 0; n < 3; n++) random_op();
    end

    req.valid <= 1'b0;
    while (n_waiting != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/shs_pkg.sv
rtl/core/shs_req_if.sv
rtl/core/shs_rsp_if.sv
rtl/core/shs_cfg_if.sv
rtl/core/shs_ram.sv
rtl/core/shs_mod.sv
rtl/core/string_hash_set_linear_probe_core.sv
dv/shs_scoreboard.sv
dv/tb_string_hash_set_linear_probe_core.sv
